### rtl/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

  // Significant bits of the input value.
  localparam int VALUE_WIDTH = 32;

  // Decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1.
  localparam int NUM_DIGITS_RAW = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int NUM_DIGITS = (NUM_DIGITS_RAW > 20) ? 20 :
                              (NUM_DIGITS_RAW < 1) ? 1 : NUM_DIGITS_RAW;

  localparam int BCD_W  = NUM_DIGITS * 4;
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int CHAR_W = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Converter to emitter handoff.
  typedef struct packed {
    logic             valid;
    logic [BCD_W-1:0] bcd;
  } conv_res_t;

endpackage

### rtl/b2da_conv.sv
`timescale 1ns / 1ps

// Shift-and-add-3 binary to BCD converter, one bit per cycle.
module b2da_conv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [b2da_pkg::VALUE_WIDTH-1:0]  value_i,
  output logic                              busy_o,
  output b2da_pkg::conv_res_t               res_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_e;

  state_e                           state_q, state_d;
  logic [b2da_pkg::VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [b2da_pkg::BCD_W-1:0]       bcd_q, bcd_d;
  logic [b2da_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                             done_q, done_d;
  logic [b2da_pkg::BCD_W-1:0]       bcd_adj;

  // Add 3 to every digit that is 5 or more before the shift.
  always_comb begin
    for (int k = 0; k < b2da_pkg::NUM_DIGITS; k++) begin
      if (bcd_q[k*4 +: 4] >= 4'd5) begin
        bcd_adj[k*4 +: 4] = bcd_q[k*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[k*4 +: 4] = bcd_q[k*4 +: 4];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          bin_d   = value_i;
          bcd_d   = '0;
          cnt_d   = b2da_pkg::CNT_W'(b2da_pkg::VALUE_WIDTH);
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bcd_d = {bcd_adj[b2da_pkg::BCD_W-2:0], bin_q[b2da_pkg::VALUE_WIDTH-1]};
        bin_d = {bin_q[b2da_pkg::VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == b2da_pkg::CNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      bin_q   <= '0;
      bcd_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      bin_q   <= bin_d;
      bcd_q   <= bcd_d;
    end
  end

  assign busy_o    = (state_q != ST_IDLE) || done_q;
  assign res_o.valid = done_q;
  assign res_o.bcd   = bcd_q;

endmodule

### rtl/b2da_emit.sv
`timescale 1ns / 1ps

// Walks the BCD word from the top digit, drops leading zeros, sends one char a cycle.
module b2da_emit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  b2da_pkg::conv_res_t                res_i,
  output logic                               busy_o,
  output logic                               digit_valid_o,
  output logic [b2da_pkg::CHAR_W-1:0]        digit_char_o,
  output logic                               last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  localparam logic [b2da_pkg::DIG_W-1:0] LAST_IDX =
    b2da_pkg::DIG_W'(b2da_pkg::NUM_DIGITS - 1);

  state_e                           state_q;
  logic [b2da_pkg::BCD_W-1:0]       bcd_q;
  logic [b2da_pkg::DIG_W-1:0]       idx_q;
  logic                             valid_q;
  logic [b2da_pkg::CHAR_W-1:0]      char_q;
  logic                             last_q;
  logic [3:0]                       top_digit;

  assign top_digit = bcd_q[b2da_pkg::BCD_W-1 -: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bcd_q   <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
      char_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (res_i.valid) begin
            bcd_q   <= res_i.bcd;
            idx_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // the least significant digit is always sent
          if ((top_digit == 4'd0) && (idx_q != LAST_IDX)) begin
            bcd_q <= {bcd_q[b2da_pkg::BCD_W-5:0], 4'd0};
            idx_q <= idx_q + 1'b1;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          valid_q <= 1'b1;
          char_q  <= b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
          last_q  <= (idx_q == LAST_IDX);
          bcd_q   <= {bcd_q[b2da_pkg::BCD_W-5:0], 4'd0};
          idx_q   <= idx_q + 1'b1;
          if (idx_q == LAST_IDX) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign digit_valid_o = valid_q;
  assign digit_char_o  = char_q;
  assign last_o        = last_q;

endmodule

### rtl/binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps

// Channel   Ports                               Handshake
// request   start, busy, value_i                taken when start && !busy
// digit     digit_valid_o, digit_char_o, last_o one-cycle strobe, no backpressure
//
// A request goes through the shift-add-3 converter, one step per bit of value_i, then the BCD
// word is handed over, the emitter scans past suppressed leading zeros, leaves the scan and
// sends the digits from the top: busy is already low in the cycle in which the last digit is
// on the ports, so a new request can be taken while that digit is shown.
// Reset is asynchronous, active low, and returns both sequencers to idle.
// Digits cannot be stalled; the receiver must take each strobe.
module binary_to_decimal_ascii_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [b2da_pkg::VALUE_WIDTH-1:0]  value_i,
  output logic                              digit_valid_o,
  output logic [b2da_pkg::CHAR_W-1:0]       digit_char_o,
  output logic                              last_o
);

  logic                conv_busy;
  logic                emit_busy;
  b2da_pkg::conv_res_t conv_res;

  b2da_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !busy),
    .value_i (value_i),
    .busy_o  (conv_busy),
    .res_o   (conv_res)
  );

  b2da_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (conv_res),
    .busy_o        (emit_busy),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_o        (last_o)
  );

  assign busy = conv_busy || emit_busy;

endmodule
